FILE: rtl/core/rmf_pkg.sv
// rmf_pkg: shared constants and types for the running median filter
// no dependencies; used by every module under rtl/core
`default_nettype none

package rmf_pkg;

  // ring depth, 1..7
  localparam int WINDOW = 5;

  localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SAMP_W = 8;
  localparam int FILL_W = 3;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;

  typedef logic [WINDOW-1:0][SAMP_W-1:0] win_t;

  // result of one pass through the rank unit
  typedef struct packed {
    logic [CNT_W-1:0]  rank;      // stable sorted position of the candidate
    logic [SAMP_W-1:0] value;     // candidate sample
    logic              in_range;  // candidate index below the fill count
  } rank_t;

endpackage

`default_nettype wire

FILE: rtl/core/running_median_filter.sv
// running median filter: one 8-bit sample in, median of the last WINDOW samples out
// flow: accept, scan candidate slots up to the median slot, then load the output register
// a new sample is taken only after the previous result is loaded into the output register
// a single shared rank unit ranks one candidate slot per cycle while scanning
// reset: rst is synchronous, active high; clears pointer, fill count, sequencer, out valid
// ring contents are not cleared; a slot is only ranked after it has been written
`default_nettype none

module running_median_filter (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // sample input stream
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [rmf_pkg::IN_TDATA_W-1:0]     s_tdata,  // [7:0] sample
  // result stream
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic [rmf_pkg::OUT_TDATA_W-1:0]         m_tdata   // [7:0] median, [10:8] fill_count
);

  rmf_pkg::win_t                   entries;
  logic [rmf_pkg::CNT_W-1:0]       count;
  logic [rmf_pkg::IDX_W-1:0]       cand;
  rmf_pkg::rank_t                  rank;
  logic [rmf_pkg::SAMP_W-1:0]      median;
  logic [rmf_pkg::FILL_W-1:0]      fill_count;
  logic                            wr_en;

  // a transfer on the input side writes the ring at once
  assign wr_en = s_tvalid && s_tready;

  rmf_ring u_ring (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_data (s_tdata[rmf_pkg::SAMP_W-1:0]),
    .entries (entries),
    .count   (count)
  );

  // shared rank unit, stepped over candidate slots by the sequencer
  rmf_rank u_rank (
    .entries (entries),
    .count   (count),
    .cand    (cand),
    .result  (rank)
  );

  // sequencer stops at the slot whose stable rank equals count/2
  rmf_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .count      (count),
    .rank       (rank),
    .cand       (cand),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_median (median),
    .out_fill   (fill_count)
  );

  // pack result fields, upper bits zero
  assign m_tdata = {{(rmf_pkg::OUT_TDATA_W - rmf_pkg::SAMP_W - rmf_pkg::FILL_W){1'b0}},
                    fill_count, median};

endmodule

`default_nettype wire

FILE: rtl/core/rmf_ring.sv
// rmf_ring: sample ring with wrapping write pointer and saturating fill count
// depends on rmf_pkg
`default_nettype none

module rmf_ring (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          wr_en,
  input  wire logic [rmf_pkg::SAMP_W-1:0]    wr_data,
  output rmf_pkg::win_t                      entries,
  output logic [rmf_pkg::CNT_W-1:0]          count
);

  rmf_pkg::win_t                 store;
  logic [rmf_pkg::IDX_W-1:0]     wptr;

  // payload, no reset: slots are read only once written
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      count <= '0;
    end else if (wr_en) begin
      if (wptr == rmf_pkg::IDX_W'(rmf_pkg::WINDOW - 1)) begin
        wptr <= '0;
      end else begin
        wptr <= wptr + 1'b1;
      end
      if (count < rmf_pkg::CNT_W'(rmf_pkg::WINDOW)) begin
        count <= count + 1'b1;
      end
    end
  end

  assign entries = store;

endmodule

`default_nettype wire

FILE: rtl/core/rmf_rank.sv
// rmf_rank: shared rank unit, stable sorted position of one candidate entry
// depends on rmf_pkg
`default_nettype none

module rmf_rank (
  input  wire rmf_pkg::win_t              entries,
  input  wire logic [rmf_pkg::CNT_W-1:0]  count,
  input  wire logic [rmf_pkg::IDX_W-1:0]  cand,
  output rmf_pkg::rank_t                  result
);

  logic [rmf_pkg::SAMP_W-1:0] cval;
  logic [rmf_pkg::CNT_W-1:0]  acc;
  logic                       below;

  always_comb begin
    cval = entries[cand];
    acc  = '0;
    for (int j = 0; j < rmf_pkg::WINDOW; j++) begin
      // ties broken by slot index so every valid entry gets a unique rank
      below = (rmf_pkg::CNT_W'(j) < count) &&
              (rmf_pkg::IDX_W'(j) != cand) &&
              ((entries[j] < cval) ||
               ((entries[j] == cval) && (rmf_pkg::IDX_W'(j) < cand)));
      acc = acc + rmf_pkg::CNT_W'(below);
    end
    result.rank     = acc;
    result.value    = cval;
    result.in_range = rmf_pkg::CNT_W'(cand) < count;
  end

endmodule

`default_nettype wire

FILE: rtl/core/rmf_seq.sv
// rmf_seq: candidate sequencer and output register of the median filter
// depends on rmf_pkg; drives the rank unit candidate index
`default_nettype none

module rmf_seq (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [rmf_pkg::CNT_W-1:0]     count,
  input  wire rmf_pkg::rank_t                rank,
  output logic [rmf_pkg::IDX_W-1:0]          cand,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [rmf_pkg::SAMP_W-1:0]         out_median,
  output logic [rmf_pkg::FILL_W-1:0]         out_fill
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t                      state;
  logic [rmf_pkg::SAMP_W-1:0]  med;
  logic                        hit;
  logic                        last;
  logic                        load;

  assign in_ready = (state == ST_IDLE);
  assign hit  = rank.in_range && (rank.rank == (count >> 1));
  assign last = (rmf_pkg::CNT_W'(cand) + 1'b1) >= count;
  assign load = (state == ST_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cand      <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_SCAN;
            cand  <= '0;
          end
        end
        ST_SCAN: begin
          if (hit || last) begin
            state <= ST_DONE;
          end else begin
            cand <= cand + 1'b1;
          end
        end
        ST_DONE: begin
          if (load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SCAN && hit) begin
      med <= rank.value;
    end
    if (load) begin
      out_median <= med;
      out_fill   <= rmf_pkg::FILL_W'(count);
    end
  end

`ifndef SYNTHESIS
  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_SCAN && cand == '0))
    else $error("accepted sample did not start a scan");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> rank.in_range)
    else $error("candidate index beyond fill count");

  a_hit_ends_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && hit) |=> (state == ST_DONE))
    else $error("median found but scan went on");

  a_result_nonempty: assert property (@(posedge clk) disable iff (rst)
    load |=> (out_valid && out_fill != '0))
    else $error("result loaded with empty window");
`endif

endmodule

`default_nettype wire

FILE: verif/median_checker.sv
// median_checker: watches both streams of the running median filter, predicts each result
// and compares it with what the block delivers; depends on rmf_pkg for window size and widths
`timescale 1ns / 100ps

module median_checker (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  input  wire logic                           s_tready,
  input  wire logic [rmf_pkg::IN_TDATA_W-1:0]  s_tdata,   // [7:0] sample
  input  wire logic                           m_tvalid,
  input  wire logic                           m_tready,
  input  wire logic [rmf_pkg::OUT_TDATA_W-1:0] m_tdata,   // [7:0] median, [10:8] fill_count
  output int                                  fail_count,
  output int                                  pending
);

  typedef struct packed {
    logic [rmf_pkg::SAMP_W-1:0] median;
    logic [rmf_pkg::FILL_W-1:0] fill_count;
  } median_result_t;

  // shadow of the block state
  logic [rmf_pkg::SAMP_W-1:0] ring [rmf_pkg::WINDOW];
  int unsigned       wr_ptr = 0;
  int unsigned       fill = 0;
  int                mismatches = 0;
  median_result_t    median_queue [$];

  // entry at sorted position n/2 among the first n ring slots
  function automatic logic [rmf_pkg::SAMP_W-1:0] window_median(input int unsigned n);
    logic [rmf_pkg::SAMP_W-1:0] ranked [rmf_pkg::WINDOW];
    logic [rmf_pkg::SAMP_W-1:0] v;
    int                i;
    int                j;
    for (i = 0; i < n; i++) ranked[i] = ring[i];
    for (i = 1; i < n; i++) begin
      v = ranked[i];
      j = i;
      while (j > 0 && ranked[j-1] > v) begin
        ranked[j] = ranked[j-1];
        j--;
      end
      ranked[j] = v;
    end
    return ranked[n/2];
  endfunction

  always @(posedge clk) begin : watch
    median_result_t got;
    median_result_t want;
    if (rst) begin
      wr_ptr = 0;
      fill   = 0;
      median_queue.delete();
    end else begin
      // results first: a sample taken at this edge cannot have produced one yet
      if (m_tvalid && m_tready) begin
        got.median     = m_tdata[rmf_pkg::SAMP_W-1:0];
        got.fill_count = m_tdata[rmf_pkg::SAMP_W+rmf_pkg::FILL_W-1:rmf_pkg::SAMP_W];
        if (median_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with nothing pending: median %0d fill %0d",
                     $realtime, got.median, got.fill_count);
        end else begin
          want = median_queue.pop_front();
          if (got.median !== want.median || got.fill_count !== want.fill_count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch: expected median %0d fill %0d, got median %0d fill %0d",
                       $realtime, want.median, want.fill_count, got.median, got.fill_count);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        ring[wr_ptr] = s_tdata[rmf_pkg::SAMP_W-1:0];
        wr_ptr = (wr_ptr + 1 == rmf_pkg::WINDOW) ? 0 : wr_ptr + 1;
        if (fill < rmf_pkg::WINDOW) fill++;
        want.median     = window_median(fill);
        want.fill_count = rmf_pkg::FILL_W'(fill);
        median_queue.push_back(want);
      end
    end
    fail_count <= mismatches;
    pending    <= median_queue.size();
  end

endmodule

FILE: verif/testbench.sv
// testbench: drives samples into the running median filter and paces its result stream
// depends on rmf_pkg, running_median_filter and median_checker, which does the result checking
`timescale 1ns / 100ps

module testbench;

  localparam int RANDOM_ITEMS = 550;
  localparam int QUIET_ITEMS  = 100;  // tail with no idling on either side
  localparam int HOLD_AT      = 250;  // random item where the long result stall starts
  localparam int HOLD_ITEMS   = 12;   // samples offered back to back during that stall
  localparam int LONG_HOLD    = 80;   // cycles the result side stays not ready
  localparam int DRAIN_CYCLES = 20;   // idle wait after the last result, to catch stray results
  localparam int RUN_LIMIT    = 2_000_000;

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [rmf_pkg::IN_TDATA_W-1:0] s_tdata;   // [7:0] sample
  logic m_tvalid;
  logic m_tready;
  logic [rmf_pkg::OUT_TDATA_W-1:0] m_tdata;  // [7:0] median, [10:8] fill_count

  int fail_count;
  int pending;

  // random idling switch and the long-stall request, shared by both sides
  bit idle_on = 1'b1;
  bit long_hold = 1'b0;

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  running_median_filter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  median_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // one sample transfer; an optional idle burst first, valid stays up between
  // back-to-back samples so it is never dropped and raised in the same step
  task automatic send_sample(input logic [7:0] value, input bit may_idle);
    int gap;
    if (may_idle && idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    // s_tready read here is the value seen at the edge just passed
    do @(posedge clk); while (!s_tready);
  endtask

  // result side: ready bursts, random stall bursts, and one long stall on request
  initial begin : result_sink
    int n;
    m_tready <= 1'b0;
    forever begin
      if (long_hold) begin
        // long stall counted here while the sender keeps offering samples
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        n = $urandom_range(1, 7);
        repeat (n) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        n = $urandom_range(1, 12);
        repeat (n) @(posedge clk);
      end
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    logic [7:0] v;
    logic [7:0] base;
    logic [7:0] ramp;
    int         sel;
    base = 8'd100;
    ramp = 8'd0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // window filling from empty: single entry, even count takes the upper median
    send_sample(8'd0, 1'b1);    send_sample(8'd255, 1'b1);  send_sample(8'd128, 1'b1);
    send_sample(8'd255, 1'b1);  send_sample(8'd255, 1'b1);
    // pointer wraps, oldest entries replaced by ties of the minimum
    send_sample(8'd0, 1'b1);    send_sample(8'd0, 1'b1);    send_sample(8'd0, 1'b1);
    send_sample(8'd1, 1'b1);    send_sample(8'd254, 1'b1);
    // descending then ascending runs
    send_sample(8'd200, 1'b1);  send_sample(8'd150, 1'b1);  send_sample(8'd100, 1'b1);
    send_sample(8'd50, 1'b1);   send_sample(8'd25, 1'b1);
    send_sample(8'd10, 1'b1);   send_sample(8'd20, 1'b1);   send_sample(8'd30, 1'b1);
    send_sample(8'd40, 1'b1);   send_sample(8'd50, 1'b1);
    // alternating extremes, every bit toggles
    send_sample(8'd255, 1'b1);  send_sample(8'd0, 1'b1);    send_sample(8'd255, 1'b1);
    send_sample(8'd0, 1'b1);    send_sample(8'd85, 1'b1);

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == RANDOM_ITEMS - QUIET_ITEMS) idle_on = 1'b0;
      if (k == HOLD_AT) begin
        // results held back: the block fills up and has to stall its input
        long_hold = 1'b1;
        for (int h = 0; h < HOLD_ITEMS; h++) send_sample(8'($urandom_range(0, 255)), 1'b0);
      end
      if ($urandom_range(0, 15) == 0) base = 8'($urandom_range(0, 252));
      sel = $urandom_range(0, 19);
      if (sel < 11) begin
        v = 8'($urandom_range(0, 255));
      end else if (sel < 16) begin
        // clustered values, lots of ties
        v = base + 8'($urandom_range(0, 3));
      end else if (sel < 18) begin
        v = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      end else begin
        // slow ramp that wraps through the whole range
        ramp = ramp + 8'($urandom_range(1, 9));
        v = ramp;
      end
      send_sample(v, 1'b1);
    end
    s_tvalid <= 1'b0;

    // drain every outstanding result, then watch for strays
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // hang guard
  initial begin : run_limit
    #(RUN_LIMIT);
    $display("testbench: done, errors");
    $finish;
  end

endmodule
